// File: design/wpp_pkg.sv
// Package for the waveform peak and pedestal block.
// Holds the item types, the controller state and command types, and fixed constants.
// No dependencies.
package wpp_pkg;

  localparam int SAMPLE_W = 12;
  localparam int IDX_W    = 8;
  localparam int SUM_W    = 18;
  localparam int SQ_W     = 30;
  localparam int CNT_W    = 7;
  localparam int NSQ_W    = CNT_W + SQ_W;
  localparam int S2_W     = 2 * SUM_W;
  localparam int ROOT_W   = (NSQ_W + 1) / 2;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int SQREM_W  = ROOT_W + 3;
  localparam int DIV_W    = ROOT_W + 4;
  localparam int MEAN_W   = 16;
  localparam int RMS_W    = 15;
  localparam int STEP_W   = 5;

  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_W - 1);

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hfff;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PED_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PED_CHANNEL = 2'd1;

  localparam logic [IDX_W-1:0] PED_START_RST   = 8'd10;
  localparam logic [1:0]       PED_CHANNEL_RST = 2'd2;

  localparam logic [1:0] CH0 = 2'd0;
  localparam logic [1:0] CH1 = 2'd1;
  localparam logic [1:0] CH2 = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw_ch0;
    logic [SAMPLE_W-1:0] raw_ch1;
    logic [SAMPLE_W-1:0] raw_ch2;
    logic                last_sample;
  } wpp_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] peak_ch0;
    logic [IDX_W-1:0]    peak_index_ch0;
    logic [SAMPLE_W-1:0] peak_ch1;
    logic [IDX_W-1:0]    peak_index_ch1;
    logic [SAMPLE_W-1:0] peak_ch2;
    logic [IDX_W-1:0]    peak_index_ch2;
    logic [MEAN_W-1:0]   ped_mean_q4;
    logic [RMS_W-1:0]    ped_rms_q4;
    logic                ped_valid;
  } wpp_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_MEAN_INIT,
    ST_MEAN,
    ST_RMS_INIT,
    ST_RMS,
    ST_EMIT
  } wpp_state_t;

  typedef struct packed {
    logic sample;
    logic prod;
    logic root_init;
    logic root_step;
    logic mean_init;
    logic rms_init;
    logic div_step;
    logic emit;
  } wpp_cmd_t;

  typedef struct packed {
    logic root_last;
    logic div_last;
  } wpp_status_t;

endpackage

// File: design/waveform_peak_and_pedestal.sv
// Result: an event's result becomes valid once the arithmetic after its last sample is done,
// or later if the previous result is still held by out_stall.
// Throughput: one item per cycle within an event; after the last sample the input stalls
// through the products, the 19-step square root and two 23-step divisions on one divider.
// Reset (rst_n low at a clock edge): event state cleared, ped_start = 10, ped_channel = 2.
// Depends on wpp_pkg, wpp_ctrl and wpp_datapath.
module waveform_peak_and_pedestal
  import wpp_pkg::*;
#(
  parameter int PED_LEN     = 20,
  parameter int MAX_SAMPLES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  wpp_in_t               in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output wpp_out_t              out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  wpp_cmd_t    cmd;
  wpp_status_t status;
  wpp_out_t    result;

  logic     out_valid_r, out_valid_nxt;
  wpp_out_t out_item_r, out_item_nxt;
  logic     out_free;

  // Configuration writes are always taken; the user must issue them only while the
  // block is idle (the block itself does not enforce it), so they take effect from the next sample.
  assign cfg_ready = 1'b1;

  // The output register frees up either when it is empty or when its item
  // leaves at this edge, so a new result can follow without a gap.
  assign out_free = !out_valid_r || !out_stall;

  // The controller takes samples while idle. On the last sample of an event
  // it stalls the input and walks the datapath through the products, the
  // square root and the two divisions, then hands the result to the output
  // register and clears the event state in the same cycle.
  wpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_item.last_sample),
    .out_free (out_free),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  wpp_datapath #(
    .PED_LEN     (PED_LEN),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = result;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: design/wpp_ctrl.sv
// Controller state machine of the waveform peak and pedestal block.
// Sequences sample intake and the end-of-event arithmetic; depends on wpp_pkg.
module wpp_ctrl
  import wpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_last,
  input  logic        out_free,
  input  wpp_status_t status,
  output logic        in_stall,
  output wpp_cmd_t    cmd
);

  wpp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.sample = in_valid;
        if (in_valid && in_last) begin
          state_nxt = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = ST_ROOT_INIT;
      end
      ST_ROOT_INIT: begin
        cmd.root_init = 1'b1;
        state_nxt     = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_nxt = ST_MEAN_INIT;
        end
      end
      ST_MEAN_INIT: begin
        cmd.mean_init = 1'b1;
        state_nxt     = ST_MEAN;
      end
      ST_MEAN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_RMS_INIT;
        end
      end
      ST_RMS_INIT: begin
        cmd.rms_init = 1'b1;
        state_nxt    = ST_RMS;
      end
      ST_RMS: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/wpp_datapath.sv
// Datapath of the waveform peak and pedestal block: per-sample peak tracking,
// pedestal sums, the square root, and the shared divider steps. Depends on wpp_pkg.
module wpp_datapath
  import wpp_pkg::*;
#(
  parameter int PED_LEN     = 20,
  parameter int MAX_SAMPLES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  wpp_in_t               in_item,
  input  wpp_cmd_t              cmd,
  output wpp_status_t           status,
  output wpp_out_t              result
);

  logic [IDX_W-1:0]    ped_start_r, ped_start_nxt;
  logic [1:0]          ped_channel_r, ped_channel_nxt;

  logic [IDX_W-1:0]    sample_index_r, sample_index_nxt;
  logic [SAMPLE_W-1:0] peak_value_r    [3];
  logic [SAMPLE_W-1:0] peak_value_nxt  [3];
  logic [IDX_W-1:0]    peak_position_r [3];
  logic [IDX_W-1:0]    peak_position_nxt [3];
  logic [SUM_W-1:0]    ped_sum_r, ped_sum_nxt;
  logic [SQ_W-1:0]     ped_sumsq_r, ped_sumsq_nxt;
  logic [CNT_W-1:0]    ped_count_r, ped_count_nxt;

  logic [NSQ_W-1:0]    nsq_r, nsq_nxt;
  logic [S2_W-1:0]     s2_r, s2_nxt;
  logic [RAD_W-1:0]    rad_r, rad_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [SQREM_W-1:0]  sq_rem_r, sq_rem_nxt;
  logic [DIV_W-1:0]    div_num_r, div_num_nxt;
  logic [CNT_W-1:0]    div_rem_r, div_rem_nxt;
  logic [MEAN_W-1:0]   mean_r, mean_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  logic [SAMPLE_W-1:0]   raw [3];
  logic [SAMPLE_W-1:0]   inv [3];
  logic [SAMPLE_W-1:0]   ped_sample;
  logic                  ped_chan_ok;
  logic                  in_window;
  logic [2*SAMPLE_W-1:0] ped_square;
  logic [NSQ_W-1:0]      s2_wide;
  logic [NSQ_W-1:0]      radicand;
  logic [SQREM_W-1:0]    sq_pre;
  logic [SQREM_W-1:0]    sq_trial;
  logic                  sq_ge;
  logic [CNT_W:0]        div_pre;
  logic [CNT_W:0]        div_diff;
  logic                  div_ge;
  logic                  n_zero;

  assign raw[0] = in_item.raw_ch0;
  assign raw[1] = in_item.raw_ch1;
  assign raw[2] = in_item.raw_ch2;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      inv[c] = SAMPLE_MAX - raw[c];
    end
  end

  always_comb begin
    ped_sample  = '0;
    ped_chan_ok = 1'b0;
    unique case (ped_channel_r)
      CH0: begin
        ped_sample  = inv[0];
        ped_chan_ok = 1'b1;
      end
      CH1: begin
        ped_sample  = inv[1];
        ped_chan_ok = 1'b1;
      end
      CH2: begin
        ped_sample  = inv[2];
        ped_chan_ok = 1'b1;
      end
      default: begin
        ped_sample  = '0;
        ped_chan_ok = 1'b0;
      end
    endcase
  end

  assign in_window = ped_chan_ok
                  && ({1'b0, sample_index_r} >= {1'b0, ped_start_r})
                  && ({1'b0, sample_index_r} < ({1'b0, ped_start_r} + (IDX_W+1)'(PED_LEN)))
                  && (ped_count_r < CNT_W'(PED_LEN));

  assign ped_square = {{SAMPLE_W{1'b0}}, ped_sample} * {{SAMPLE_W{1'b0}}, ped_sample};

  // One restoring step of the digit-by-digit square root.
  assign sq_pre   = {sq_rem_r[SQREM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = sq_pre >= sq_trial;

  // One restoring step of the divider; the divisor is the pedestal count.
  assign div_pre  = {div_rem_r, div_num_r[DIV_W-1]};
  assign div_diff = div_pre - {1'b0, ped_count_r};
  assign div_ge   = div_pre >= {1'b0, ped_count_r};

  assign s2_wide  = {{(NSQ_W-S2_W){1'b0}}, s2_r};
  assign radicand = (nsq_r > s2_wide) ? (nsq_r - s2_wide) : '0;

  always_comb begin
    ped_start_nxt   = ped_start_r;
    ped_channel_nxt = ped_channel_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PED_START:   ped_start_nxt   = cfg_data;
        CFG_PED_CHANNEL: ped_channel_nxt = cfg_data[1:0];
        default: begin
          ped_start_nxt   = ped_start_r;
          ped_channel_nxt = ped_channel_r;
        end
      endcase
    end
  end

  always_comb begin
    sample_index_nxt = sample_index_r;
    ped_sum_nxt      = ped_sum_r;
    ped_sumsq_nxt    = ped_sumsq_r;
    ped_count_nxt    = ped_count_r;
    for (int c = 0; c < 3; c++) begin
      peak_value_nxt[c]    = peak_value_r[c];
      peak_position_nxt[c] = peak_position_r[c];
    end
    if (cmd.emit) begin
      sample_index_nxt = '0;
      ped_sum_nxt      = '0;
      ped_sumsq_nxt    = '0;
      ped_count_nxt    = '0;
      for (int c = 0; c < 3; c++) begin
        peak_value_nxt[c]    = '0;
        peak_position_nxt[c] = '0;
      end
    end else if (cmd.sample) begin
      for (int c = 0; c < 3; c++) begin
        // Strictly larger only, so the first occurrence of a peak is kept.
        if (inv[c] > peak_value_r[c]) begin
          peak_value_nxt[c]    = inv[c];
          peak_position_nxt[c] = sample_index_r;
        end
      end
      if (in_window) begin
        ped_sum_nxt   = ped_sum_r + SUM_W'(ped_sample);
        ped_sumsq_nxt = ped_sumsq_r + SQ_W'(ped_square);
        ped_count_nxt = ped_count_r + CNT_W'(1);
      end
      if (sample_index_r < IDX_W'(MAX_SAMPLES - 1)) begin
        sample_index_nxt = sample_index_r + IDX_W'(1);
      end
    end
  end

  always_comb begin
    nsq_nxt     = nsq_r;
    s2_nxt      = s2_r;
    rad_nxt     = rad_r;
    root_nxt    = root_r;
    sq_rem_nxt  = sq_rem_r;
    div_num_nxt = div_num_r;
    div_rem_nxt = div_rem_r;
    mean_nxt    = mean_r;
    step_nxt    = step_r;
    if (cmd.prod) begin
      nsq_nxt = {{SQ_W{1'b0}}, ped_count_r} * {{CNT_W{1'b0}}, ped_sumsq_r};
      s2_nxt  = {{SUM_W{1'b0}}, ped_sum_r} * {{SUM_W{1'b0}}, ped_sum_r};
    end
    if (cmd.root_init) begin
      rad_nxt    = {{(RAD_W-NSQ_W){1'b0}}, radicand};
      root_nxt   = '0;
      sq_rem_nxt = '0;
      step_nxt   = '0;
    end
    if (cmd.root_step) begin
      rad_nxt    = {rad_r[RAD_W-3:0], 2'b00};
      root_nxt   = {root_r[ROOT_W-2:0], sq_ge};
      sq_rem_nxt = sq_ge ? (sq_pre - sq_trial) : sq_pre;
      step_nxt   = step_r + STEP_W'(1);
    end
    if (cmd.mean_init) begin
      div_num_nxt = {{(DIV_W-SUM_W-4){1'b0}}, ped_sum_r, 4'b0000};
      div_rem_nxt = '0;
      step_nxt    = '0;
    end
    if (cmd.rms_init) begin
      mean_nxt    = div_num_r[MEAN_W-1:0];
      div_num_nxt = {root_r, 4'b0000};
      div_rem_nxt = '0;
      step_nxt    = '0;
    end
    if (cmd.div_step) begin
      div_num_nxt = {div_num_r[DIV_W-2:0], div_ge};
      div_rem_nxt = div_ge ? div_diff[CNT_W-1:0] : div_pre[CNT_W-1:0];
      step_nxt    = step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ped_start_r    <= PED_START_RST;
      ped_channel_r  <= PED_CHANNEL_RST;
      sample_index_r <= '0;
      ped_sum_r      <= '0;
      ped_sumsq_r    <= '0;
      ped_count_r    <= '0;
      step_r         <= '0;
      for (int c = 0; c < 3; c++) begin
        peak_value_r[c]    <= '0;
        peak_position_r[c] <= '0;
      end
    end else begin
      ped_start_r    <= ped_start_nxt;
      ped_channel_r  <= ped_channel_nxt;
      sample_index_r <= sample_index_nxt;
      ped_sum_r      <= ped_sum_nxt;
      ped_sumsq_r    <= ped_sumsq_nxt;
      ped_count_r    <= ped_count_nxt;
      step_r         <= step_nxt;
      for (int c = 0; c < 3; c++) begin
        peak_value_r[c]    <= peak_value_nxt[c];
        peak_position_r[c] <= peak_position_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    nsq_r     <= nsq_nxt;
    s2_r      <= s2_nxt;
    rad_r     <= rad_nxt;
    root_r    <= root_nxt;
    sq_rem_r  <= sq_rem_nxt;
    div_num_r <= div_num_nxt;
    div_rem_r <= div_rem_nxt;
    mean_r    <= mean_nxt;
  end

  assign status.root_last = (step_r == ROOT_LAST);
  assign status.div_last  = (step_r == DIV_LAST);

  // An empty pedestal reports zero mean and rms.
  assign n_zero = (ped_count_r == '0);

  assign result.peak_ch0       = peak_value_r[0];
  assign result.peak_index_ch0 = peak_position_r[0];
  assign result.peak_ch1       = peak_value_r[1];
  assign result.peak_index_ch1 = peak_position_r[1];
  assign result.peak_ch2       = peak_value_r[2];
  assign result.peak_index_ch2 = peak_position_r[2];
  assign result.ped_mean_q4    = n_zero ? '0 : mean_r;
  assign result.ped_rms_q4     = n_zero ? '0 : div_num_r[RMS_W-1:0];
  assign result.ped_valid      = (ped_count_r == CNT_W'(PED_LEN));

endmodule
